// File: rtl/lpht_pkg.sv
package lpht_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned TOTAL_W = 11;

  localparam logic [PCT_W-1:0] LOAD_RESET = 7'd75;
  localparam logic [PCT_W-1:0] LOAD_MIN   = 7'd25;
  localparam logic [PCT_W-1:0] LOAD_MAX   = 7'd95;
  localparam logic [PCT_W-1:0] PERCENT    = 7'd100;

  typedef enum logic [1:0] {
    FUNC_GET = 2'd0,
    FUNC_PUT = 2'd1,
    FUNC_DEL = 2'd2,
    FUNC_CLR = 2'd3
  } func_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic probe;
    logic shift;
    logic fin;
    logic sweep;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_clear;
    logic in_now;
    logic probe_end;
    logic del_hit;
    logic shift_end;
    logic sweep_last;
  } sts_t;

endpackage

// File: rtl/lpht_req_if.sv
interface lpht_req_if;
  import lpht_pkg::*;

  logic             valid;
  logic             ready;
  func_e            func;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

// File: rtl/lpht_rsp_if.sv
interface lpht_rsp_if;
  import lpht_pkg::*;

  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   old_value;
  logic               found;
  logic               status;
  logic [TOTAL_W-1:0] entry_total;

  modport source (output valid, output old_value, output found, output status,
                  output entry_total, input ready);
  modport sink   (input valid, input old_value, input found, input status,
                  input entry_total, output ready);
endinterface

// File: rtl/lpht_cfg_if.sv
interface lpht_cfg_if;
  import lpht_pkg::*;

  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/linear_probe_hash_table_unit.sv
// channel | dir | word                                    | handshake
// req     | in  | func, key, value                        | valid / ready
// rsp     | out | old_value, found, status, entry_total   | valid / ready
// cfg     | in  | data = load_percent                     | valid / ready (always ready)
//
// one item at a time; a zero key or a refused put is answered from ST_IDLE without a probe
// keyed get/put: ST_IDLE then ST_PROBE, one slot read per cycle on the table port
// a delete that hits adds the backward shift in ST_SHIFT, slot by slot, then ST_FIN
// clear sweeps every slot in ST_CLR, as ST_INIT does after reset (one slot per cycle)
// a waiting result blocks the next item until taken; rst_ni is async, active low
module linear_probe_hash_table_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  lpht_req_if.sink   req,
  lpht_rsp_if.source rsp,
  lpht_cfg_if.sink   cfg
);
  import lpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpht_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (req.func),
    .key_i        (req.key),
    .value_i      (req.value),
    .cfg_valid_i  (cfg.valid),
    .cfg_data_i   (cfg.data),
    .old_value_o  (rsp.old_value),
    .found_o      (rsp.found),
    .status_o     (rsp.status),
    .entry_total_o(rsp.entry_total)
  );

endmodule

// File: rtl/lpht_ctrl.sv
module lpht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  lpht_pkg::sts_t sts_i,
  output lpht_pkg::cmd_t cmd_o
);
  import lpht_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PROBE = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_CLR   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   finish;
  logic   in_fire;

  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    finish  = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          cmd_o.start = 1'b1;
          if (sts_i.in_clear) state_d = ST_CLR;
          else if (sts_i.in_now) finish = 1'b1;
          else state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.probe_end) begin
          if (sts_i.del_hit) begin
            state_d = ST_SHIFT;
          end else begin
            finish  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_end) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        finish    = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_CLR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/lpht_dp.sv
module lpht_dp #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpht_pkg::cmd_t                cmd_i,
  output lpht_pkg::sts_t                sts_o,
  input  lpht_pkg::func_e               func_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  logic [lpht_pkg::VAL_W-1:0]    value_i,
  input  logic                          cfg_valid_i,
  input  logic [lpht_pkg::PCT_W-1:0]    cfg_data_i,
  output logic [lpht_pkg::VAL_W-1:0]    old_value_o,
  output logic                          found_o,
  output logic                          status_o,
  output logic [lpht_pkg::TOTAL_W-1:0]  entry_total_o
);
  import lpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned CMP_W = CNT_W + 8;
  localparam int unsigned EXT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
  localparam logic [IDX_W-1:0] IDX_LAST = {IDX_W{1'b1}};

  slot_t mem [TABLE_DEPTH];
  slot_t rd_q;

  func_e            func_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [IDX_W-1:0] pos_q, pos_d, prev_q, prev_d, steps_q, steps_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             zero_used_q, zero_used_d;
  logic [VAL_W-1:0] zero_val_q, zero_val_d;
  logic [PCT_W-1:0] pct_q, pct_cl;
  logic [VAL_W-1:0] res_old_q, res_old_d;
  logic             res_found_q, res_found_d, res_status_q, res_status_d;

  logic             we;
  logic [IDX_W-1:0] waddr;
  slot_t            wdata;

  logic [CMP_W-1:0] lhs, rhs;
  logic             full, empty, hit, last, in_range;
  logic [IDX_W-1:0] home_s;
  logic [EXT_W-1:0] cnt_ext;

  // refused when (count+1)*100 > 2**IDX_W*pct, i.e. count >= floor(2**IDX_W*pct/100)
  always_comb begin
    if (pct_q < LOAD_MIN)      pct_cl = LOAD_MIN;
    else if (pct_q > LOAD_MAX) pct_cl = LOAD_MAX;
    else                       pct_cl = pct_q;
  end
  assign lhs  = (CMP_W'(count_q) + CMP_W'(1)) * CMP_W'(PERCENT);
  assign rhs  = CMP_W'(pct_cl) << IDX_W;
  assign full = lhs > rhs;

  assign empty  = (rd_q.key == '0);
  assign hit    = (rd_q.key == key_q);
  assign last   = (steps_q == IDX_LAST);
  assign home_s = rd_q.key[IDX_W-1:0];

  // is the entry's home cyclically in (prev, pos]
  always_comb begin
    if (prev_q <= pos_q) in_range = (home_s > prev_q) && (home_s <= pos_q);
    else                 in_range = (home_s > prev_q) || (home_s <= pos_q);
  end

  always_comb begin
    sts_o            = '0;
    sts_o.in_clear   = (func_i == FUNC_CLR);
    sts_o.in_now     = (key_i == '0) || ((func_i == FUNC_PUT) && full);
    sts_o.probe_end  = empty || hit || last;
    sts_o.del_hit    = (func_q == FUNC_DEL) && hit;
    sts_o.shift_end  = empty || last;
    sts_o.sweep_last = (pos_q == IDX_LAST);
  end

  always_comb begin
    pos_d        = pos_q;
    prev_d       = prev_q;
    steps_d      = steps_q;
    count_d      = count_q;
    zero_used_d  = zero_used_q;
    zero_val_d   = zero_val_q;
    res_old_d    = res_old_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    we           = 1'b0;
    waddr        = pos_q;
    wdata        = '0;

    if (cmd_i.start) begin
      pos_d        = key_i[IDX_W-1:0];
      steps_d      = '0;
      res_old_d    = '0;
      res_found_d  = 1'b0;
      res_status_d = 1'b0;
      case (func_i)
        FUNC_CLR: begin
          pos_d       = '0;
          count_d     = '0;
          zero_used_d = 1'b0;
        end
        FUNC_PUT: begin
          if (full) begin
            res_status_d = 1'b1;
          end else if (key_i == '0) begin
            res_found_d = zero_used_q;
            res_old_d   = zero_used_q ? zero_val_q : '0;
            if (!zero_used_q) count_d = count_q + 1'b1;
            zero_used_d = 1'b1;
            zero_val_d  = value_i;
          end
        end
        FUNC_DEL: begin
          if (key_i == '0) begin
            res_found_d = zero_used_q;
            res_old_d   = zero_used_q ? zero_val_q : '0;
            if (zero_used_q) begin
              zero_used_d = 1'b0;
              if (count_q != '0) count_d = count_q - 1'b1;
            end
          end
        end
        default: begin
          res_found_d = zero_used_q;
          res_old_d   = zero_used_q ? zero_val_q : '0;
        end
      endcase
    end

    if (cmd_i.probe) begin
      if (!(empty || hit || last)) begin
        pos_d   = pos_q + 1'b1;
        steps_d = steps_q + 1'b1;
      end else begin
        res_found_d = hit;
        res_old_d   = hit ? rd_q.value : '0;
        case (func_q)
          FUNC_PUT: begin
            if (hit || empty) begin
              we    = 1'b1;
              wdata = '{key: key_q, value: val_q};
              if (!hit) count_d = count_q + 1'b1;
            end
          end
          FUNC_DEL: begin
            if (hit) begin
              if (count_q != '0) count_d = count_q - 1'b1;
              prev_d  = pos_q;
              pos_d   = pos_q + 1'b1;
              steps_d = IDX_W'(1);
            end
          end
          default: ;
        endcase
      end
    end

    // moves fill the hole at prev; the last is only written once the chain walk ends
    if (cmd_i.shift) begin
      if (!empty && !in_range) begin
        we     = 1'b1;
        waddr  = prev_q;
        wdata  = rd_q;
        prev_d = pos_q;
      end
      if (!(empty || last)) begin
        pos_d   = pos_q + 1'b1;
        steps_d = steps_q + 1'b1;
      end
    end

    if (cmd_i.fin) begin
      we    = 1'b1;
      waddr = prev_q;
    end

    if (cmd_i.sweep) begin
      we    = 1'b1;
      pos_d = pos_q + 1'b1;
    end
  end

  // read address follows the next slot so data lines up with pos_q
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[pos_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q <= func_i;
      key_q  <= key_i;
      val_q  <= value_i;
    end
    prev_q       <= prev_d;
    steps_q      <= steps_d;
    zero_val_q   <= zero_val_d;
    res_old_q    <= res_old_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      count_q     <= '0;
      zero_used_q <= 1'b0;
      pct_q       <= LOAD_RESET;
    end else begin
      pos_q       <= pos_d;
      count_q     <= count_d;
      zero_used_q <= zero_used_d;
      if (cfg_valid_i) pct_q <= cfg_data_i;
    end
  end

  assign cnt_ext       = EXT_W'(count_q);
  assign entry_total_o = cnt_ext[TOTAL_W-1:0];
  assign old_value_o   = res_old_q;
  assign found_o       = res_found_q;
  assign status_o      = res_status_q;

endmodule

// File: rtl/lpht_checker.sv
module lpht_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [lpht_pkg::VAL_W-1:0]   rsp_old_value_i,
  input logic                         rsp_found_i,
  input logic                         rsp_status_i,
  input logic [lpht_pkg::TOTAL_W-1:0] rsp_entry_total_i
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_old_value_i)
      && $stable(rsp_found_i) && $stable(rsp_status_i) && $stable(rsp_entry_total_i))
    else $error("rsp word changed while stalled");

  // refused put reports nothing found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i |-> !rsp_found_i && (rsp_old_value_i == '0))
    else $error("refused put with data");

  // absent key gives zero old value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |-> rsp_old_value_i == '0)
    else $error("old value without found");

  // no new item while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |-> !rsp_valid_i)
    else $error("item taken while result pending");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req.valid),
  .req_ready_i      (req.ready),
  .rsp_valid_i      (rsp.valid),
  .rsp_ready_i      (rsp.ready),
  .rsp_old_value_i  (rsp.old_value),
  .rsp_found_i      (rsp.found),
  .rsp_status_i     (rsp.status),
  .rsp_entry_total_i(rsp.entry_total)
);
